/* rtl/sobel_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sobel_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_THRESHOLD    = 2'd2,
        CFG_EDGE_LEVEL   = 2'd3
    } t_cfg_idx;

    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [8:0]  RST_THRESHOLD    = 9'd250;
    localparam logic [7:0]  RST_EDGE_LEVEL   = 8'd100;

    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_W      = 10;

    // x / 30 for 0 <= x <= 1020 equals (x * 2185) >> 16
    localparam int DIV30_RECIP = 2185;
    localparam int DIV30_SHIFT = 16;

    localparam int GRAD_W   = 12;
    localparam int SUMSQ_W  = 17;
    localparam int THRSQ_W  = 19;

    typedef logic [7:0] t_pixel;

    // 3x3 neighborhood: top, middle, bottom rows; left, center, right columns
    typedef struct packed {
        t_pixel tl;
        t_pixel tc;
        t_pixel tr;
        t_pixel ml;
        t_pixel mc;
        t_pixel mr;
        t_pixel bl;
        t_pixel bc;
        t_pixel br;
    } t_window;

    typedef struct packed {
        logic interior;
        logic last;
    } t_pos_flags;

endpackage

`default_nettype wire

/* rtl/sobel_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface sobel_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface sobel_edge_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_pixel;
    logic       last_of_frame;

    modport source (output valid, output edge_pixel, output last_of_frame, input ready);
    modport sink   (input valid, input edge_pixel, input last_of_frame, output ready);
endinterface

`default_nettype wire

/* rtl/sobel_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module sobel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/sobel_grad.sv */
`timescale 1ns / 1ps
`default_nettype none

module sobel_grad import sobel_pkg::*; (
    input  wire t_window    i_win,
    output logic [7:0]      o_a,
    output logic [7:0]      o_b
);

    // divide toward zero by 30, keep the low byte
    function automatic logic [7:0] scale(input logic signed [GRAD_W-1:0] s);
        logic [GRAD_W-1:0]   mag;
        logic [2*GRAD_W-1:0] prod;
        logic [7:0]          q;
        mag  = s[GRAD_W-1] ? GRAD_W'(-s) : GRAD_W'(s);
        prod = (2*GRAD_W)'(mag) * (2*GRAD_W)'(DIV30_RECIP);
        q    = prod[DIV30_SHIFT +: 8];
        return s[GRAD_W-1] ? 8'(-q) : q;
    endfunction

    function automatic logic signed [GRAD_W-1:0] ext(input t_pixel p);
        return $signed({{(GRAD_W-8){1'b0}}, p});
    endfunction

    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] dm;
    logic signed [GRAD_W-1:0] dc;

    always_comb begin
        dm = ext(i_win.mr) - ext(i_win.ml);
        dc = ext(i_win.tc) - ext(i_win.bc);
        gx = (ext(i_win.tr) - ext(i_win.tl)) + dm + dm + (ext(i_win.br) - ext(i_win.bl));
        gy = (ext(i_win.tl) + ext(i_win.tr)) - (ext(i_win.bl) + ext(i_win.br)) + dc + dc;
    end

    assign o_a = scale(gx);
    assign o_b = scale(gy);

endmodule

`default_nettype wire

/* rtl/sobel_edge_threshold_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: pixel transfer to result through the line read, gradient and magnitude stages.
// Throughput: one pixel per cycle; the pipeline advances whenever the result register
// is empty or being taken, and the line store takes one read and one write per cycle.
// Reset: synchronous, active low; restores register defaults, clears counters, window
// and valid flags. Line store contents are left as they are.
module sobel_edge_threshold_unit import sobel_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    sobel_pixel_if.sink                i_pix,
    sobel_edge_if.source               o_edge
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

    // configuration
    logic [10:0] r_width;
    logic [10:0] r_height;
    logic [8:0]  r_thr;
    logic [7:0]  r_level;
    logic [THRSQ_W-1:0] r_thr_sq;
    logic [9:0]  thr_p1;
    logic [19:0] thr_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_thr    <= RST_THRESHOLD;
            r_level  <= RST_EDGE_LEVEL;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                CFG_THRESHOLD:    r_thr    <= i_cfg_data[8:0];
                CFG_EDGE_LEVEL:   r_level  <= i_cfg_data[7:0];
            endcase
        end
    end

    // floor(sqrt(n)) > t  <=>  n >= (t+1)^2
    assign thr_p1   = 10'(r_thr) + 10'd1;
    assign thr_prod = 20'(thr_p1) * 20'(thr_p1);

    always_ff @(posedge i_clk) begin
        r_thr_sq <= thr_prod[THRSQ_W-1:0];
    end

    // pipeline control
    logic en;
    logic acc;
    logic r_out_valid;

    assign en          = !r_out_valid || o_edge.ready;
    assign acc         = i_pix.valid && en;
    assign i_pix.ready = en;

    // position of the incoming pixel
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [LW-1:0]    w_raw;
    logic [LW-1:0]    w_lim;
    logic [LW-1:0]    w_m1;
    logic [LW-1:0]    col_x;
    logic [10:0]      h_lim;
    logic [10:0]      h_m1;
    logic [10:0]      row_x;
    logic             col_end;
    logic             row_end;
    t_pos_flags       pos;

    always_comb begin
        w_raw = LW'(r_width);
        if (w_raw < LW'(MIN_DIM)) begin
            w_lim = LW'(MIN_DIM);
        end else if (w_raw > LW'(MAX_WIDTH)) begin
            w_lim = LW'(MAX_WIDTH);
        end else begin
            w_lim = w_raw;
        end
        if (r_height < 11'(MIN_DIM)) begin
            h_lim = 11'(MIN_DIM);
        end else if (r_height > 11'(MAX_HEIGHT)) begin
            h_lim = 11'(MAX_HEIGHT);
        end else begin
            h_lim = r_height;
        end
        w_m1    = w_lim - LW'(1);
        h_m1    = h_lim - 11'd1;
        col_x   = LW'(r_col);
        row_x   = 11'(r_row);
        col_end = col_x >= w_m1;
        row_end = row_x >= h_m1;
        pos.interior = (row_x >= 11'd2) && (col_x >= LW'(2)) &&
                       (row_x <= h_m1) && (col_x <= w_m1);
        pos.last     = (row_x == h_m1) && (col_x == w_m1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // stage 1: pixel with the two stored rows above it
    logic          r_s1_valid;
    t_pixel        r_s1_pixel;
    logic [CW-1:0] r_s1_col;
    t_pos_flags    r_s1_flags;
    logic [15:0]   ram_q;
    logic          ram_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pixel <= i_pix.pixel;
            r_s1_col   <= r_col;
            r_s1_flags <= pos;
        end
    end

    assign ram_we = en && r_s1_valid;

    // upper byte: row two above, lower byte: row directly above
    sobel_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_col),
        .i_wdata ({ram_q[7:0], r_s1_pixel}),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    t_pixel  r_win [6];
    t_window win;
    logic [7:0] grad_a;
    logic [7:0] grad_b;

    always_comb begin
        win.tl = r_win[0];
        win.ml = r_win[1];
        win.bl = r_win[2];
        win.tc = r_win[3];
        win.mc = r_win[4];
        win.bc = r_win[5];
        win.tr = ram_q[15:8];
        win.mr = ram_q[7:0];
        win.br = r_s1_pixel;
    end

    // shift the window one column when the stage 1 pixel advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (ram_we) begin
            r_win[0] <= win.tc;
            r_win[1] <= win.mc;
            r_win[2] <= win.bc;
            r_win[3] <= win.tr;
            r_win[4] <= win.mr;
            r_win[5] <= win.br;
        end
    end

    sobel_grad u_grad (
        .i_win (win),
        .o_a   (grad_a),
        .o_b   (grad_b)
    );

    // stage 2: magnitude against threshold
    logic       r_s2_valid;
    logic [7:0] r_s2_a;
    logic [7:0] r_s2_b;
    logic       r_s2_last;
    logic [SUMSQ_W-1:0] sum_sq;
    logic       hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid && r_s1_flags.interior;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_a    <= grad_a;
            r_s2_b    <= grad_b;
            r_s2_last <= r_s1_flags.last;
        end
    end

    assign sum_sq = SUMSQ_W'(16'(r_s2_a) * 16'(r_s2_a)) + SUMSQ_W'(16'(r_s2_b) * 16'(r_s2_b));
    assign hit    = THRSQ_W'(sum_sq) >= r_thr_sq;

    // result register
    t_pixel r_out_pixel;
    logic   r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_pixel <= hit ? r_level : 8'd0;
            r_out_last  <= r_s2_last;
        end
    end

    assign o_edge.valid         = r_out_valid;
    assign o_edge.edge_pixel    = r_out_pixel;
    assign o_edge.last_of_frame = r_out_last;

`ifndef SYNTHESIS
    a_ram_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && acc) |-> (r_s1_col != r_col))
        else $error("line store read and write hit the same column");

    a_last_wraps_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_flags.last) |-> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap after the last pixel of a frame");

    a_edge_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_edge.valid && o_edge.edge_pixel != 8'd0) |-> (o_edge.edge_pixel == r_level))
        else $error("edge result differs from the programmed edge level");
`endif

endmodule

`default_nettype wire
